@@ design/lowest_common_ancestor_walk_unit_assert.svh @@
// Assertion helpers shared by the walk unit modules.
`ifndef LOWEST_COMMON_ANCESTOR_WALK_UNIT_ASSERT_SVH
`define LOWEST_COMMON_ANCESTOR_WALK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCAW_ASSERT_IMPLY(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!(rstn_sig)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LCAW_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!(rstn_sig)) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/lcaw_pkg.sv @@
package lcaw_pkg;

    localparam int NODE_W = 12;

    typedef logic [NODE_W-1:0] node_t;

    typedef enum logic
    {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_t;

    typedef enum logic [2:0]
    {
        ST_INIT,
        ST_IDLE,
        ST_MARK,
        ST_SETUP_B,
        ST_SEARCH,
        ST_SETUP_A,
        ST_UNMARK,
        ST_DONE
    } state_t;

    typedef enum logic [2:0]
    {
        NODE_HOLD    = 3'd0,
        NODE_IN      = 3'd1,
        NODE_SAVED_A = 3'd2,
        NODE_SAVED_B = 3'd3,
        NODE_PARENT  = 3'd4
    } node_sel_t;

    // Commands from controller to datapath
    typedef struct packed
    {
        node_sel_t node_sel;
        logic      step_clr;
        logic      step_inc;
        logic      mark_we;
        logic      mark_val;
        logic      par_load_we;
        logic      init_we;
        logic      query_start;
        logic      set_hit;
        logic      out_load;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed
    {
        logic init_last;
        logic in_a_zero;
        logic a_zero;
        logic b_zero;
        logic walk_end;
        logic cur_marked;
        logic out_free;
    } dp_stat_t;

endpackage

@@ design/lowest_common_ancestor_walk_unit.sv @@
// Load transaction: accepted while idle, no result.
// Query transaction: walks up from node_a marking each node, then walks up from node_b until a
// marked node (the ancestor) is found, then walks from node_a again clearing the marks; each walk
// visits at most MAX_NODES nodes, and the result waits for the output register to be free.
// One item in flight; a finished result waits in the output register while the next is taken.
// Reset (rst_n, async, active low) clears all min(MAX_NODES, 4096) parent and mark entries.
module lowest_common_ancestor_walk_unit
    import lcaw_pkg::*;
#(
    parameter int MAX_NODES = 4096
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  req_type,
    input  node_t node_a,
    input  node_t node_b,
    output logic  out_valid,
    input  logic  out_stall,
    output node_t ancestor,
    output logic  found
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lcaw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    lcaw_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .node_a    (node_a),
        .node_b    (node_b),
        .cmd       (cmd),
        .stat      (stat),
        .ancestor  (ancestor),
        .found     (found),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

@@ design/lcaw_ram.sv @@
module lcaw_ram
#(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/lcaw_ctrl.sv @@
`include "lowest_common_ancestor_walk_unit_assert.svh"

module lcaw_ctrl
    import lcaw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     req_type,
    output logic     in_stall,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init_we = 1'b1;
                if (stat.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        cmd.par_load_we = 1'b1;
                    end
                    else
                    begin
                        cmd.node_sel    = NODE_IN;
                        cmd.step_clr    = 1'b1;
                        cmd.query_start = 1'b1;
                        state_next      = stat.in_a_zero ? ST_SETUP_B : ST_MARK;
                    end
                end
            end
            ST_MARK:
            begin
                cmd.mark_we  = 1'b1;
                cmd.mark_val = 1'b1;
                cmd.step_inc = 1'b1;
                cmd.node_sel = NODE_PARENT;
                if (stat.walk_end)
                begin
                    state_next = ST_SETUP_B;
                end
            end
            ST_SETUP_B:
            begin
                cmd.node_sel = NODE_SAVED_B;
                cmd.step_clr = 1'b1;
                state_next   = stat.b_zero ? ST_SETUP_A : ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (stat.cur_marked)
                begin
                    cmd.set_hit = 1'b1;
                    state_next  = ST_SETUP_A;
                end
                else
                begin
                    cmd.step_inc = 1'b1;
                    cmd.node_sel = NODE_PARENT;
                    if (stat.walk_end)
                    begin
                        state_next = ST_SETUP_A;
                    end
                end
            end
            ST_SETUP_A:
            begin
                cmd.node_sel = NODE_SAVED_A;
                cmd.step_clr = 1'b1;
                state_next   = stat.a_zero ? ST_DONE : ST_UNMARK;
            end
            ST_UNMARK:
            begin
                cmd.mark_we  = 1'b1;
                cmd.mark_val = 1'b0;
                cmd.step_inc = 1'b1;
                cmd.node_sel = NODE_PARENT;
                if (stat.walk_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    `LCAW_ASSERT_IMPLY(a_load_only_idle, clk, rst_n, cmd.par_load_we, state_reg == ST_IDLE,
        "parent table written outside idle")
    `LCAW_ASSERT_IMPLY(a_mark_only_walk, clk, rst_n, cmd.mark_we,
        state_reg == ST_MARK || state_reg == ST_UNMARK, "mark written outside a marking walk")
    `LCAW_ASSERT_NEXT(a_query_starts_walk, clk, rst_n,
        state_reg == ST_IDLE && in_valid && req_type == REQ_QUERY,
        state_reg == ST_MARK || state_reg == ST_SETUP_B, "query did not start a walk")

endmodule

@@ design/lcaw_dp.sv @@
`include "lowest_common_ancestor_walk_unit_assert.svh"

module lcaw_dp
    import lcaw_pkg::*;
#(
    parameter int MAX_NODES = 4096
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  node_t    node_a,
    input  node_t    node_b,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    output node_t    ancestor,
    output logic     found,
    output logic     out_valid,
    input  logic     out_stall
);

    localparam int DEPTH  = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int STEP_W = $clog2(MAX_NODES + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_NODES - 1);
    localparam logic [ADDR_W-1:0] INIT_LAST = ADDR_W'(DEPTH - 1);

    node_t              node_reg;
    node_t              node_next;
    node_t              a_reg;
    node_t              b_reg;
    logic [STEP_W-1:0]  steps_reg;
    logic [STEP_W-1:0]  steps_next;
    logic [ADDR_W-1:0]  init_cnt_reg;
    node_t              anc_reg;
    logic               hit_reg;
    node_t              ancestor_reg;
    logic               found_reg;
    logic               out_valid_reg;

    logic               cur_in_range;
    logic               in_a_range;
    node_t              p_rd;
    logic               m_rd;
    node_t              parent_cur;
    logic               p_we;
    logic [ADDR_W-1:0]  p_waddr;
    node_t              p_wdata;
    logic               m_we;
    logic [ADDR_W-1:0]  m_waddr;
    logic               m_wdata;

    // Range checks: nodes at or above the table size have no parent and no mark
    assign cur_in_range = {{(32-NODE_W){1'b0}}, node_reg} < 32'(MAX_NODES);
    assign in_a_range   = {{(32-NODE_W){1'b0}}, node_a} < 32'(MAX_NODES);
    assign parent_cur   = cur_in_range ? p_rd : '0;

    // Select the next walk position
    always_comb
    begin
        unique case (cmd.node_sel)
            NODE_HOLD:    node_next = node_reg;
            NODE_IN:      node_next = node_a;
            NODE_SAVED_A: node_next = a_reg;
            NODE_SAVED_B: node_next = b_reg;
            NODE_PARENT:  node_next = parent_cur;
            default:      node_next = node_reg;
        endcase
    end

    // Step counter bounds each walk
    always_comb
    begin
        priority if (cmd.step_clr)
        begin
            steps_next = '0;
        end
        else if (cmd.step_inc)
        begin
            steps_next = steps_reg + STEP_W'(1);
        end
        else
        begin
            steps_next = steps_reg;
        end
    end

    // Parent table: clear pass or load transaction
    assign p_we    = cmd.init_we | (cmd.par_load_we & in_a_range & (node_a != '0));
    assign p_waddr = cmd.init_we ? init_cnt_reg : node_a[ADDR_W-1:0];
    assign p_wdata = cmd.init_we ? '0 : node_b;

    // Mark store: clear pass or walk update
    assign m_we    = cmd.init_we | (cmd.mark_we & cur_in_range);
    assign m_waddr = cmd.init_we ? init_cnt_reg : node_reg[ADDR_W-1:0];
    assign m_wdata = cmd.init_we ? 1'b0 : cmd.mark_val;

    lcaw_ram #(
        .WIDTH (NODE_W),
        .DEPTH (DEPTH)
    ) u_parent_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (node_next[ADDR_W-1:0]),
        .rdata (p_rd)
    );

    lcaw_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_mark_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (node_next[ADDR_W-1:0]),
        .rdata (m_rd)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg  <= '0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            steps_reg <= steps_next;
            if (cmd.init_we)
            begin
                init_cnt_reg <= init_cnt_reg + ADDR_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        if (cmd.query_start)
        begin
            a_reg   <= node_a;
            b_reg   <= node_b;
            anc_reg <= '0;
            hit_reg <= 1'b0;
        end
        else if (cmd.set_hit)
        begin
            anc_reg <= node_reg;
            hit_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            ancestor_reg <= anc_reg;
            found_reg    <= hit_reg;
        end
    end

    // Status back to the controller
    assign stat.init_last  = (init_cnt_reg == INIT_LAST);
    assign stat.in_a_zero  = (node_a == '0);
    assign stat.a_zero     = (a_reg == '0);
    assign stat.b_zero     = (b_reg == '0);
    assign stat.walk_end   = (parent_cur == '0) || (steps_reg == STEP_LAST);
    assign stat.cur_marked = cur_in_range & m_rd;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign ancestor  = ancestor_reg;
    assign found     = found_reg;
    assign out_valid = out_valid_reg;

    `LCAW_ASSERT_IMPLY(a_hit_nonzero, clk, rst_n, out_valid_reg && found_reg,
        ancestor_reg != '0, "found ancestor is node zero")
    `LCAW_ASSERT_IMPLY(a_miss_zero, clk, rst_n, out_valid_reg && !found_reg,
        ancestor_reg == '0, "ancestor nonzero without a hit")
    `LCAW_ASSERT_IMPLY(a_step_bound, clk, rst_n, cmd.step_inc, steps_reg <= STEP_LAST,
        "walk ran past the step limit")

endmodule
